[hdl/tlbpw_pkg.sv]
// ----------------------------------------------------------------------------
// tlbpw_pkg
// Shared types and constants for the TLB with two-level page walk: item
// structs, controller/datapath command and status, and address constants.
// ----------------------------------------------------------------------------
package tlbpw_pkg;

    // Address layout
    localparam int ADDR_W  = 32;
    localparam int OFS_W   = 12;
    localparam int TAG_W   = ADDR_W - OFS_W;
    localparam int DIR_LSB = 22;

    localparam logic [ADDR_W-1:0] PAGE_MASK = 32'hffff_f000;

    // Victim LFSR (Galois, shifts right)
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam int          LFSR_W    = 16;
    localparam int          DIV_CNT_W = 1;

    // Configuration register indexes (word address bit)
    localparam logic CFG_IDX_PAGING = 1'b0;
    localparam logic CFG_IDX_DIR    = 1'b1;

    // Item kind codes
    localparam logic KIND_XLATE = 1'b0;
    localparam logic KIND_RDATA = 1'b1;
    localparam logic OUT_PHYS   = 1'b0;
    localparam logic OUT_READ   = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] lin_addr;
        logic [ADDR_W-1:0] read_data;
    } t_in_item;

    typedef struct packed {
        logic              out_kind;
        logic [ADDR_W-1:0] out_addr;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DIR,
        PH_TBL
    } t_walk_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CMP,
        ST_ENC,
        ST_HITCHK,
        ST_HITRD,
        ST_MOD,
        ST_EMIT
    } t_ctrl_state;

    typedef enum logic [2:0] {
        RES_PASS,
        RES_HIT,
        RES_DIR,
        RES_TBL,
        RES_FILL
    } t_res_sel;

    // Controller -> datapath
    typedef struct packed {
        logic     cap_item;
        logic     load_res;
        t_res_sel res_sel;
        logic     save_pend;
        logic     pick_inv;
        logic     lfsr_step;
        logic     mod_step;
        logic     fill;
        logic     out_load;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic kind;
        logic hit;
        logic inv_found;
        logic mod_last;
        logic out_free;
    } t_dp_sts;

endpackage

[hdl/tlbpw_ffs.sv]
// ----------------------------------------------------------------------------
// tlbpw_ffs
// Two-stage registered find-first-set over an N-bit vector. Stage one finds
// the lowest set bit inside each 16-bit group, stage two picks the lowest
// group. The result is registered at the end of each stage.
// ----------------------------------------------------------------------------
module tlbpw_ffs #(
    parameter int N = 64,
    localparam int IDX_W = $clog2(N)
) (
    input  logic             i_clk,
    input  logic [N-1:0]     i_vec,
    output logic             o_found,
    output logic [IDX_W-1:0] o_idx
);

    localparam int GRP = 16;
    localparam int LW  = $clog2(GRP);
    localparam int G   = (N + GRP - 1) / GRP;
    localparam int GW  = (G > 1) ? $clog2(G) : 1;

    logic [G*GRP-1:0] pad;
    logic [G-1:0]     grp_any;
    logic [G-1:0]     r_grp_any;
    logic [LW-1:0]    grp_idx [G];
    logic [LW-1:0]    r_grp_idx [G];
    logic [GW-1:0]    sel;
    logic [LW-1:0]    loc;
    logic [GW+LW-1:0] full;

    assign pad = (G*GRP)'(i_vec);

    // stage 1: lowest set bit in each group
    always_comb begin
        for (int g = 0; g < G; g++) begin
            grp_any[g] = |pad[g*GRP +: GRP];
            grp_idx[g] = '0;
            for (int b = GRP - 1; b >= 0; b--) begin
                if (pad[g*GRP + b]) begin
                    grp_idx[g] = LW'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_any <= grp_any;
        r_grp_idx <= grp_idx;
    end

    // stage 2: lowest group with a set bit
    always_comb begin
        sel = '0;
        loc = '0;
        for (int g = G - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                sel = GW'(g);
                loc = r_grp_idx[g];
            end
        end
        full = {sel, loc};
    end

    always_ff @(posedge i_clk) begin
        o_found <= |r_grp_any;
        o_idx   <= full[IDX_W-1:0];
    end

endmodule

[hdl/tlbpw_dp.sv]
// ----------------------------------------------------------------------------
// tlbpw_dp
// Datapath: item register, tag CAM with valid bits, frame memory, hit and
// free-entry encoders, victim LFSR with modulo unit, walk address adders
// and the output register.
// ----------------------------------------------------------------------------
module tlbpw_dp import tlbpw_pkg::*; #(
    parameter int ENTRIES = 64,
    localparam int IDX_W = $clog2(ENTRIES)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  t_in_item    i_in_item,
    input  logic [TAG_W-1:0] i_dir_frame,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output t_out_item   o_out_item
);

    // remainder by ENTRIES through a rounded-up reciprocal, exact for 16 bits
    localparam int                MOD_SH    = LFSR_W + IDX_W;
    localparam logic [LFSR_W+1:0] MOD_RECIP = (LFSR_W+2)'(
        ((64'd1 << MOD_SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));

    t_in_item           r_item;
    logic [ADDR_W-1:0]  r_pend;
    logic [TAG_W-1:0]   r_tag [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [TAG_W-1:0]   r_frame_mem [ENTRIES];
    logic [TAG_W-1:0]   r_frame_rd;
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] r_match;
    logic [ENTRIES-1:0] r_inv;
    logic               hit_found;
    logic [IDX_W-1:0]   hit_idx;
    logic               inv_found;
    logic [IDX_W-1:0]   inv_idx;
    logic [IDX_W-1:0]   r_victim;
    logic [LFSR_W-1:0]  r_lfsr;
    logic [LFSR_W-1:0]  n_lfsr;
    logic [LFSR_W-1:0]  r_div;
    logic [LFSR_W-1:0]  r_quot;
    logic [2*LFSR_W+1:0] mod_prod;
    logic [LFSR_W-1:0]  quot_mul;
    logic [IDX_W-1:0]   n_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [ADDR_W-1:0]  res_addr;
    logic               res_kind;
    t_out_item          r_res;
    logic               r_out_valid;
    t_out_item          r_out;

    // item capture and saved walk address
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_item <= i_in_item;
        end
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (i_cmd.save_pend) begin
            r_pend <= r_item.lin_addr;
        end
    end

    // tag compare, one comparator per entry
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_tag[i] == r_item.lin_addr[ADDR_W-1:OFS_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_match <= match;
        r_inv   <= ~r_valid;
    end

    tlbpw_ffs #(.N(ENTRIES)) u_hit_enc (
        .i_clk   (i_clk),
        .i_vec   (r_match),
        .o_found (hit_found),
        .o_idx   (hit_idx)
    );

    tlbpw_ffs #(.N(ENTRIES)) u_inv_enc (
        .i_clk   (i_clk),
        .i_vec   (r_inv),
        .o_found (inv_found),
        .o_idx   (inv_idx)
    );

    // tags and valid bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_tag[r_victim] <= r_pend[ADDR_W-1:OFS_W];
        end
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.fill) begin
            r_valid[r_victim] <= 1'b1;
        end
    end

    // frame memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_frame_mem[r_victim] <= r_item.read_data[ADDR_W-1:OFS_W];
        end
        r_frame_rd <= r_frame_mem[hit_idx];
    end

    // LFSR step, then remainder: quotient, then subtract
    assign n_lfsr   = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : '0);
    assign mod_prod = (2*LFSR_W+2)'(r_div) * (2*LFSR_W+2)'(MOD_RECIP);
    assign quot_mul = LFSR_W'(r_quot * LFSR_W'(ENTRIES));
    assign n_rem    = IDX_W'(r_div - quot_mul);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr    <= LFSR_SEED;
            r_victim  <= '0;
            r_div_cnt <= '0;
            r_div     <= '0;
            r_quot    <= '0;
        end else begin
            if (i_cmd.lfsr_step) begin
                r_lfsr    <= n_lfsr;
                r_div     <= n_lfsr;
                r_div_cnt <= '0;
            end else if (i_cmd.mod_step) begin
                if (r_div_cnt == '0) begin
                    r_quot <= LFSR_W'(mod_prod >> MOD_SH);
                end
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (i_cmd.pick_inv) begin
                r_victim <= inv_idx;
            end else if (i_cmd.mod_step && (r_div_cnt != '0)) begin
                r_victim <= n_rem;
            end
        end
    end

    // result select
    always_comb begin
        case (i_cmd.res_sel)
            RES_PASS: begin
                res_kind = OUT_PHYS;
                res_addr = r_item.lin_addr;
            end
            RES_HIT: begin
                res_kind = OUT_PHYS;
                res_addr = {r_frame_rd, r_item.lin_addr[OFS_W-1:0]};
            end
            RES_DIR: begin
                res_kind = OUT_READ;
                res_addr = {i_dir_frame, {OFS_W{1'b0}}}
                         + ADDR_W'({r_item.lin_addr[ADDR_W-1:DIR_LSB], 2'b00});
            end
            RES_TBL: begin
                res_kind = OUT_READ;
                res_addr = (r_item.read_data & PAGE_MASK)
                         + ADDR_W'({r_pend[DIR_LSB-1:OFS_W], 2'b00});
            end
            RES_FILL: begin
                res_kind = OUT_PHYS;
                res_addr = {r_item.read_data[ADDR_W-1:OFS_W], r_pend[OFS_W-1:0]};
            end
            default: begin
                res_kind = OUT_PHYS;
                res_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_res.out_kind <= res_kind;
            r_res.out_addr <= res_addr;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // status to the controller
    assign o_sts.kind      = r_item.kind;
    assign o_sts.hit       = hit_found;
    assign o_sts.inv_found = inv_found;
    assign o_sts.mod_last  = (r_div_cnt == {DIV_CNT_W{1'b1}});
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

[hdl/tlbpw_ctrl.sv]
// ----------------------------------------------------------------------------
// tlbpw_ctrl
// Controller: sequences one item at a time through decode, CAM lookup,
// victim selection and result transfer; holds the page-walk phase.
// ----------------------------------------------------------------------------
module tlbpw_ctrl import tlbpw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_paging,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    t_walk_phase r_phase;
    t_walk_phase n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_IDLE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // next state and walk phase
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_sts.kind == KIND_XLATE) begin
                    if (r_phase != PH_IDLE) begin
                        n_state = ST_IDLE;
                    end else if (!i_paging) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_CMP;
                    end
                end else begin
                    case (r_phase)
                        PH_DIR: begin
                            n_state = ST_EMIT;
                            n_phase = PH_TBL;
                        end
                        PH_TBL: begin
                            n_state = ST_EMIT;
                            n_phase = PH_IDLE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CMP: begin
                n_state = ST_ENC;
            end
            ST_ENC: begin
                n_state = ST_HITCHK;
            end
            ST_HITCHK: begin
                if (i_sts.hit) begin
                    n_state = ST_HITRD;
                end else begin
                    n_phase = PH_DIR;
                    n_state = i_sts.inv_found ? ST_EMIT : ST_MOD;
                end
            end
            ST_HITRD: begin
                n_state = ST_EMIT;
            end
            ST_MOD: begin
                if (i_sts.mod_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.res_sel = RES_PASS;
        case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.cap_item = i_in_valid;
            end
            ST_DECODE: begin
                if (i_sts.kind == KIND_XLATE) begin
                    if (r_phase == PH_IDLE && !i_paging) begin
                        o_cmd.load_res = 1'b1;
                        o_cmd.res_sel  = RES_PASS;
                    end
                end else if (r_phase == PH_DIR) begin
                    o_cmd.load_res = 1'b1;
                    o_cmd.res_sel  = RES_TBL;
                end else if (r_phase == PH_TBL) begin
                    o_cmd.load_res = 1'b1;
                    o_cmd.res_sel  = RES_FILL;
                    o_cmd.fill     = 1'b1;
                end
            end
            ST_HITCHK: begin
                if (!i_sts.hit) begin
                    o_cmd.save_pend = 1'b1;
                    o_cmd.load_res  = 1'b1;
                    o_cmd.res_sel   = RES_DIR;
                    o_cmd.pick_inv  = i_sts.inv_found;
                    o_cmd.lfsr_step = !i_sts.inv_found;
                end
            end
            ST_HITRD: begin
                o_cmd.load_res = 1'b1;
                o_cmd.res_sel  = RES_HIT;
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

[hdl/tlb_with_page_walk.sv]
// ----------------------------------------------------------------------------
// tlb_with_page_walk
// Fully associative TLB for 32-bit linear addresses with a two-level page
// walk through memory read requests; APB registers for paging and the
// page directory frame.
//
//   channel  direction  signals                               payload
//   in       input      i_in_valid / o_in_ready               t_in_item
//   out      output     o_out_valid / i_out_ready             t_out_item
//   cfg      apb slave  psel penable pwrite paddr pwdata ...  32-bit data
//
// One item is in flight at a time, sequenced by the controller. Stray
// items return to ready after decode; walk read data and paging-off
// passthrough go to transfer; a lookup adds CAM compare, the two-stage
// encoder, then a frame memory read on a hit or, if every entry is valid,
// the LFSR modulo unit on a miss. Synchronous reset clears valid bits and
// the walk; a stalled output holds the controller in its transfer state.
// ----------------------------------------------------------------------------
module tlb_with_page_walk import tlbpw_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             r_paging;
    logic [TAG_W-1:0] r_dir_frame;
    logic             cfg_wr;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paging    <= 1'b0;
            r_dir_frame <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == CFG_IDX_PAGING) begin
                r_paging <= pwdata[0];
            end else begin
                r_dir_frame <= pwdata[TAG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_DIR) ? 32'(r_dir_frame) : 32'(r_paging);

    tlbpw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_paging   (r_paging),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tlbpw_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_dir_frame (r_dir_frame),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
